// File: sv/gfc_pkg.sv
// ----------------------------------------------------------------------------
// gfc_pkg
// Shared types, constants and the seven-segment table of the gated
// frequency counter.
// ----------------------------------------------------------------------------
`default_nettype none

package gfc_pkg;

	// field widths
	localparam int unsigned SampleW = 12;
	localparam int unsigned GateW   = 24;
	localparam int unsigned CountW  = 11;
	localparam int unsigned CyclesW = 10;
	localparam int unsigned DigitW  = 4;
	localparam int unsigned RemW    = 7;
	localparam int unsigned SegW    = 7;
	localparam int unsigned CfgIdxW = 2;

	// register reset values
	localparam logic [SampleW-1:0] THRESHOLD_RESET = 12'd1352;
	localparam logic [GateW-1:0]   GATE_RESET      = 24'd100000;

	// limits
	localparam logic [CountW-1:0]  CROSS_MAX  = 11'd2047;
	localparam logic [CyclesW-1:0] CYCLES_MAX = 10'd999;

	// decimal point on the ones digit
	localparam logic [7:0] DP_BIT = 8'd128;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_GATE      = 2'd1
	} cfg_idx_t;

	// saturated count split into hundreds and the remainder below 100
	typedef struct packed {
		logic [CyclesW-1:0] cycles;
		logic               overflow;
		logic [DigitW-1:0]  hundreds;
		logic [RemW-1:0]    rem;
	} split_t;

	// segment code of one decimal digit, bit 0 is segment a
	function automatic logic [SegW-1:0] seg_code(input logic [DigitW-1:0] digit);
		logic [SegW-1:0] code;
		case (digit)
			4'd0:    code = 7'h3F;
			4'd1:    code = 7'h06;
			4'd2:    code = 7'h5B;
			4'd3:    code = 7'h4F;
			4'd4:    code = 7'h66;
			4'd5:    code = 7'h6D;
			4'd6:    code = 7'h7D;
			4'd7:    code = 7'h07;
			4'd8:    code = 7'h7F;
			4'd9:    code = 7'h6F;
			default: code = 7'h00;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

// File: sv/gfc_window.sv
// ----------------------------------------------------------------------------
// gfc_window
// Crossing detector, crossing counter and gate window position. Emits the
// window's crossing count into a one-entry stage at the end of each window.
// ----------------------------------------------------------------------------
`default_nettype none

module gfc_window (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [gfc_pkg::SampleW-1:0]   threshold,
	input  wire logic [gfc_pkg::GateW-1:0]     gate_length,
	input  wire logic                          up_valid,
	output logic                               up_stall,
	input  wire logic [gfc_pkg::SampleW-1:0]   sample,
	output logic                               dn_valid,
	input  wire logic                          dn_stall,
	output logic [gfc_pkg::CountW-1:0]         dn_count
);

	logic                        level_q;
	logic [gfc_pkg::CountW-1:0]  cross_q;
	logic [gfc_pkg::GateW-1:0]   pos_q;
	logic                        valid_s1;
	logic [gfc_pkg::CountW-1:0]  count_s1;

	logic                        accept;
	logic                        crossing;
	logic [gfc_pkg::CountW-1:0]  cross_next;
	logic [gfc_pkg::GateW-1:0]   pos_next;
	logic [gfc_pkg::GateW-1:0]   gate_eff;
	logic                        win_end;

	// take a sample when the event stage is empty or draining
	assign up_stall = valid_s1 && dn_stall;
	assign accept   = up_valid && !up_stall;

	// threshold crossing, an equal sample always toggles
	always_comb begin
		crossing = (!level_q && (sample >= threshold)) || (level_q && (sample <= threshold));
		cross_next = cross_q;
		if (crossing && (cross_q != gfc_pkg::CROSS_MAX)) begin
			cross_next = cross_q + gfc_pkg::CountW'(1);
		end
	end

	// window end, a zero gate length acts as one
	always_comb begin
		pos_next = pos_q + gfc_pkg::GateW'(1);
		gate_eff = (gate_length == '0) ? gfc_pkg::GateW'(1) : gate_length;
		win_end  = (pos_next == '0) || (pos_next >= gate_eff);
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			cross_q <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			level_q <= level_q ^ crossing;
			if (win_end) begin
				cross_q <= '0;
				pos_q   <= '0;
			end else begin
				cross_q <= cross_next;
				pos_q   <= pos_next;
			end
		end
	end

	// end-of-window event stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= win_end;
		end else if (!dn_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && win_end) begin
			count_s1 <= cross_next;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_count = count_s1;

endmodule

`default_nettype wire

// File: sv/gfc_digits.sv
// ----------------------------------------------------------------------------
// gfc_digits
// Halves and saturates the crossing count and splits off the hundreds
// digit by a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module gfc_digits (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        up_valid,
	output logic                             up_stall,
	input  wire logic [gfc_pkg::CountW-1:0]  up_count,
	output logic                             dn_valid,
	input  wire logic                        dn_stall,
	output gfc_pkg::split_t                  dn_split
);

	logic                         valid_s2;
	gfc_pkg::split_t              split_s2;

	logic                         accept;
	logic [gfc_pkg::CyclesW-1:0]  half;
	logic                         ovf;
	logic [gfc_pkg::CyclesW-1:0]  cyc;
	logic [15:0]                  prod_h;
	logic [gfc_pkg::DigitW-1:0]   hund;
	logic [gfc_pkg::CyclesW-1:0]  hund_x100;
	logic [gfc_pkg::CyclesW-1:0]  rem_full;
	gfc_pkg::split_t              split_d;

	assign up_stall = valid_s2 && dn_stall;
	assign accept   = up_valid && !up_stall;

	// full periods, saturated, then hundreds = cyc * 41 >> 12 (exact below 1000)
	always_comb begin
		half      = up_count[gfc_pkg::CountW-1:1];
		ovf       = half > gfc_pkg::CYCLES_MAX;
		cyc       = ovf ? gfc_pkg::CYCLES_MAX : half;
		prod_h    = 16'(cyc) * 16'd41;
		hund      = prod_h[15:12];
		hund_x100 = {hund, 6'b0} + {1'b0, hund, 5'b0} + {4'b0, hund, 2'b0};
		rem_full  = cyc - hund_x100;
		split_d.cycles   = cyc;
		split_d.overflow = ovf;
		split_d.hundreds = hund;
		split_d.rem      = rem_full[gfc_pkg::RemW-1:0];
	end

	// split stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (accept) begin
			valid_s2 <= 1'b1;
		end else if (!dn_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			split_s2 <= split_d;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_split = split_s2;

endmodule

`default_nettype wire

// File: sv/gfc_segs.sv
// ----------------------------------------------------------------------------
// gfc_segs
// Splits the remainder into tens and ones and registers the result item
// with its seven-segment codes.
// ----------------------------------------------------------------------------
`default_nettype none

module gfc_segs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         up_valid,
	output logic                              up_stall,
	input  wire gfc_pkg::split_t              up_split,
	output logic                              dn_valid,
	input  wire logic                         dn_stall,
	output logic [gfc_pkg::CyclesW-1:0]       cycles,
	output logic                              overflow,
	output logic [gfc_pkg::SegW-1:0]          seg_hundreds,
	output logic [gfc_pkg::SegW-1:0]          seg_tens,
	output logic [7:0]                        seg_ones
);

	logic                         valid_q;
	logic [gfc_pkg::CyclesW-1:0]  cycles_q;
	logic                         overflow_q;
	logic [gfc_pkg::SegW-1:0]     seg_h_q;
	logic [gfc_pkg::SegW-1:0]     seg_t_q;
	logic [7:0]                   seg_o_q;

	logic                         accept;
	logic [14:0]                  prod_t;
	logic [gfc_pkg::DigitW-1:0]   tens;
	logic [gfc_pkg::RemW-1:0]     tens_x10;
	logic [gfc_pkg::RemW-1:0]     ones_full;

	assign up_stall = valid_q && dn_stall;
	assign accept   = up_valid && !up_stall;

	// tens = rem * 205 >> 11 (exact below 100), ones is what is left
	always_comb begin
		prod_t    = 15'(up_split.rem) * 15'd205;
		tens      = prod_t[14:11];
		tens_x10  = {tens, 3'b0} + {2'b0, tens, 1'b0};
		ones_full = up_split.rem - tens_x10;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (!dn_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cycles_q   <= up_split.cycles;
			overflow_q <= up_split.overflow;
			seg_h_q    <= gfc_pkg::seg_code(up_split.hundreds);
			seg_t_q    <= gfc_pkg::seg_code(tens);
			seg_o_q    <= {1'b0, gfc_pkg::seg_code(ones_full[gfc_pkg::DigitW-1:0])}
				| gfc_pkg::DP_BIT;
		end
	end

	assign dn_valid     = valid_q;
	assign cycles       = cycles_q;
	assign overflow     = overflow_q;
	assign seg_hundreds = seg_h_q;
	assign seg_tens     = seg_t_q;
	assign seg_ones     = seg_o_q;

endmodule

`default_nettype wire

// File: sv/gated_frequency_counter_7seg.sv
// ----------------------------------------------------------------------------
// gated_frequency_counter_7seg
// Counts threshold crossings of an ADC sample stream over a gate window
// and reports full periods with seven-segment codes at each window end.
// ----------------------------------------------------------------------------
// throughput: one sample per cycle while sample_stall is low
// result path: the result of a window-ending sample is registered in turn in the
//   event stage, digit split stage and result register
// reset: arst_n clears level flag, crossing count, window position and all
//   valid bits; threshold and gate_length return to 1352 and 100000
`default_nettype none

module gated_frequency_counter_7seg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration writes
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [gfc_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [gfc_pkg::GateW-1:0]     cfg_data,
	// sample items
	input  wire logic                          sample_valid,
	output logic                               sample_stall,
	input  wire logic [gfc_pkg::SampleW-1:0]   sample,
	// result items
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [gfc_pkg::CyclesW-1:0]        cycles,
	output logic                               overflow,
	output logic [gfc_pkg::SegW-1:0]           seg_hundreds,
	output logic [gfc_pkg::SegW-1:0]           seg_tens,
	output logic [7:0]                         seg_ones
);

	logic [gfc_pkg::SampleW-1:0]  threshold_q;
	logic [gfc_pkg::GateW-1:0]    gate_q;

	logic                         evt_valid;
	logic                         evt_stall;
	logic [gfc_pkg::CountW-1:0]   evt_count;
	logic                         split_valid;
	logic                         split_stall;
	gfc_pkg::split_t              split;

	// configuration registers, unknown indexes are ignored
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= gfc_pkg::THRESHOLD_RESET;
			gate_q      <= gfc_pkg::GATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gfc_pkg::CFG_THRESHOLD: threshold_q <= cfg_data[gfc_pkg::SampleW-1:0];
				gfc_pkg::CFG_GATE:      gate_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// crossing detection and gate window
	gfc_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.threshold   (threshold_q),
		.gate_length (gate_q),
		.up_valid    (sample_valid),
		.up_stall    (sample_stall),
		.sample      (sample),
		.dn_valid    (evt_valid),
		.dn_stall    (evt_stall),
		.dn_count    (evt_count)
	);

	// saturation and hundreds split
	gfc_digits u_digits (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (evt_valid),
		.up_stall (evt_stall),
		.up_count (evt_count),
		.dn_valid (split_valid),
		.dn_stall (split_stall),
		.dn_split (split)
	);

	// tens and ones, segment codes, result register
	gfc_segs u_segs (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (split_valid),
		.up_stall     (split_stall),
		.up_split     (split),
		.dn_valid     (result_valid),
		.dn_stall     (result_stall),
		.cycles       (cycles),
		.overflow     (overflow),
		.seg_hundreds (seg_hundreds),
		.seg_tens     (seg_tens),
		.seg_ones     (seg_ones)
	);

endmodule

`default_nettype wire
